[sv/bpa_pkg.sv]
// Shared constants, types and table-address helpers for the buddy page allocator.
// Depends on nothing; every other file of the block imports it.
package bpa_pkg;

  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned ORDER_COUNT = 8;
  localparam int unsigned NUM_PAGES   = 1024;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned TBL_DEPTH  = 2 * NUM_PAGES;
  localparam int unsigned TBL_AW     = $clog2(TBL_DEPTH);
  localparam int unsigned ORD_W      = 3;
  localparam int unsigned SPAN_BYTES = NUM_PAGES * PAGE_BYTES;

  typedef logic [TBL_AW-1:0] taddr_t;
  typedef logic [ORD_W-1:0]  ord_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam ord_t TOP_ORDER = ORD_W'(ORDER_COUNT - 1);

  typedef enum logic [1:0] {
    ST_BELONGS, ST_FREE, ST_SPLIT, ST_ALLOC
  } bstat_t;

  typedef enum logic [2:0] {
    RS_OK, RS_ZERO_SIZE, RS_TOO_LARGE, RS_NO_FREE, RS_OUT_OF_RANGE, RS_NOT_ALLOC
  } rstat_t;

  typedef enum logic {
    OP_ALLOC, OP_FREE
  } op_t;

  typedef enum logic {
    LOP_REMOVE, LOP_APPEND
  } lop_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START,
    S_A_SPLIT_CHECK, S_A_SPLIT_MARK, S_A_CHILD0, S_A_CHILD1, S_A_DESC,
    S_A_TAKE, S_A_TAKE_W, S_A_TAKE_L,
    S_F_SCAN, S_F_SCAN_W, S_F_BUD, S_F_BUD_W, S_F_RM_BUD, S_F_MERGE, S_F_MERGE2, S_F_UP,
    S_L_START, S_L_RHEAD, S_L_READ, S_L_EVAL, S_L_RFIX,
    S_FIN
  } fsm_t;

  // Free-list link of one block: a valid flag and the index of the next block.
  typedef struct packed {
    logic valid;
    idx_t idx;
  } link_t;

  // Access bundle for the two table memories (status and link).
  typedef struct packed {
    logic   st_we;
    taddr_t st_waddr;
    bstat_t st_wdata;
    taddr_t st_raddr;
    logic   ln_we;
    taddr_t ln_waddr;
    link_t  ln_wdata;
    taddr_t ln_raddr;
  } tbl_req_t;

  function automatic cnt_t order_cnt(ord_t k);
    return CNT_W'(NUM_PAGES >> k);
  endfunction

  function automatic taddr_t order_base(ord_t k);
    int unsigned acc;
    acc = 0;
    for (int unsigned j = 0; j < ORDER_COUNT; j++) begin
      if (j < 32'(k)) acc += NUM_PAGES >> j;
    end
    return TBL_AW'(acc);
  endfunction

  function automatic taddr_t slot(ord_t k, idx_t i);
    return order_base(k) + TBL_AW'(i);
  endfunction

endpackage

[sv/bpa_table.sv]
// Block status and free-list link memories of the buddy page allocator.
// Depends on bpa_pkg; one write and one registered read per memory and cycle.
module bpa_table
  import bpa_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output bstat_t   st_rdata,
  output link_t    ln_rdata
);

  bstat_t st_mem [TBL_DEPTH];
  link_t  ln_mem [TBL_DEPTH];
  bstat_t st_rdata_r;
  link_t  ln_rdata_r;

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (req.st_we) st_mem[req.st_waddr] <= req.st_wdata;
    if (req.st_we && req.st_waddr == req.st_raddr) st_rdata_r <= req.st_wdata;
    else st_rdata_r <= st_mem[req.st_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.ln_we) ln_mem[req.ln_waddr] <= req.ln_wdata;
    if (req.ln_we && req.ln_waddr == req.ln_raddr) ln_rdata_r <= req.ln_wdata;
    else ln_rdata_r <= ln_mem[req.ln_raddr];
  end

  assign st_rdata = st_rdata_r;
  assign ln_rdata = ln_rdata_r;

endmodule

[sv/buddy_page_allocator.sv]
// Top level of the buddy page allocator: request sequencer, free-list heads and result register.
// Depends on bpa_pkg and bpa_table.
//
//   Channel   Direction  Handshake             Beat contents
//   in_       input      in_valid / in_ready   op, alloc_size, free_address
//   out_      output     out_valid / out_ready status, result_address, block_order, block_index
//   cfg_      input      cfg_we                base_address (cfg_wdata)
//
// After reset the block runs a clearing pass that writes the reset contents of all 2048
// table entries; in_ready stays low during it, cfg writes are taken.
// One request is worked on at a time. Every list step is a link read followed by a
// check, and a walk on order k visits at most (1024 >> k) + 1 links.
// The single read port of each table memory sets the pace of every list walk.
// A finished result waits in the output register; the next request is accepted
// while it waits, and is only held at its end until the register is free.
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_alloc_size,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_address,
  output logic [2:0]  out_block_order,
  output logic [9:0]  out_block_index,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // Sequencer state, including the shared list-walk routine and its return point.
  fsm_t   state_r, state_nxt;
  fsm_t   ret_r, ret_nxt;
  lop_t   lop_r, lop_nxt;
  ord_t   lk_r, lk_nxt;
  idx_t   lidx_r, lidx_nxt;
  idx_t   cur_r, cur_nxt;
  cnt_t   n_r, n_nxt;
  taddr_t clr_r, clr_nxt;

  // Request under work.
  op_t    op_r, op_nxt;
  logic   zero_r, zero_nxt;
  logic   big_r, big_nxt;
  logic   oor_r, oor_nxt;
  ord_t   req_r, req_nxt;
  idx_t   page_r, page_nxt;
  ord_t   k_r, k_nxt;
  idx_t   idx_r, idx_nxt;
  rstat_t res_status_r, res_status_nxt;
  ord_t   res_ord_r, res_ord_nxt;
  idx_t   res_idx_r, res_idx_nxt;

  // Free-list heads: a valid flag per order in flops, one head read per cycle.
  idx_t   head_r [ORDER_COUNT];
  idx_t   head_nxt [ORDER_COUNT];
  logic [ORDER_COUNT-1:0] hv_r, hv_nxt;

  logic [31:0] base_r, base_nxt;

  logic        out_valid_r, out_valid_nxt;
  rstat_t      out_status_r, out_status_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  ord_t        out_ord_r, out_ord_nxt;
  idx_t        out_idx_r, out_idx_nxt;

  tbl_req_t tbl;
  bstat_t   st_rdata;
  link_t    ln_rdata;

  ord_t   hsel;
  idx_t   hd;
  logic   found;
  ord_t   fk;

  logic [32:0] size_sum;
  logic [32-PAGE_SHIFT:0] pages;
  logic   rq_ok;
  ord_t   rq;
  logic [32:0] diff;

  taddr_t ofs;
  cnt_t   ofs1;
  idx_t   pidx;
  idx_t   bud;
  taddr_t ls;

  bpa_table u_table (
    .clk      (clk),
    .req      (tbl),
    .st_rdata (st_rdata),
    .ln_rdata (ln_rdata)
  );

  assign hd = head_r[hsel];

  // Lowest non-empty free list at or above the requested order.
  always_comb begin
    found = 1'b0;
    fk    = '0;
    for (int j = ORDER_COUNT - 1; j >= 0; j--) begin
      if (ORD_W'(j) >= req_r && hv_r[j]) begin
        found = 1'b1;
        fk    = ORD_W'(j);
      end
    end
  end

  // Request decode: page count, order needed, and address bounds.
  always_comb begin
    size_sum = {1'b0, in_alloc_size} + 33'(PAGE_BYTES - 1);
    pages    = size_sum[32:PAGE_SHIFT];
    rq_ok    = 1'b0;
    rq       = '0;
    for (int j = ORDER_COUNT - 1; j >= 0; j--) begin
      if (pages <= (33-PAGE_SHIFT)'(64'd1 << j)) begin
        rq_ok = 1'b1;
        rq    = ORD_W'(j);
      end
    end
    diff = {1'b0, in_free_address} - {1'b0, base_r};
  end

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    lop_nxt        = lop_r;
    lk_nxt         = lk_r;
    lidx_nxt       = lidx_r;
    cur_nxt        = cur_r;
    n_nxt          = n_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    zero_nxt       = zero_r;
    big_nxt        = big_r;
    oor_nxt        = oor_r;
    req_nxt        = req_r;
    page_nxt       = page_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_ord_nxt    = res_ord_r;
    res_idx_nxt    = res_idx_r;
    head_nxt       = head_r;
    hv_nxt         = hv_r;
    base_nxt       = cfg_we ? cfg_wdata : base_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_ord_nxt    = out_ord_r;
    out_idx_nxt    = out_idx_r;
    tbl            = '0;
    hsel           = lk_r;
    ofs            = clr_r - order_base(TOP_ORDER);
    ofs1           = CNT_W'(ofs) + CNT_W'(1);
    pidx           = page_r >> k_r;
    bud            = idx_r ^ IDX_W'(1);
    ls             = slot(lk_r, lidx_r);

    case (state_r)
      S_CLEAR: begin
        // Write the reset contents: top-order blocks free and chained by index.
        tbl.st_we    = 1'b1;
        tbl.st_waddr = clr_r;
        tbl.ln_we    = 1'b1;
        tbl.ln_waddr = clr_r;
        if (clr_r >= order_base(TOP_ORDER) && CNT_W'(ofs) < order_cnt(TOP_ORDER)) begin
          tbl.st_wdata = ST_FREE;
          if (ofs1 < order_cnt(TOP_ORDER)) begin
            tbl.ln_wdata.valid = 1'b1;
            tbl.ln_wdata.idx   = ofs1[IDX_W-1:0];
          end
        end
        clr_nxt = clr_r + TBL_AW'(1);
        if (clr_r == TBL_AW'(TBL_DEPTH - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(in_op);
          zero_nxt = (in_alloc_size == 32'd0);
          big_nxt  = !rq_ok;
          req_nxt  = rq;
          oor_nxt  = diff[32] || (diff >= 33'(SPAN_BYTES));
          page_nxt = diff[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_status_nxt = RS_OK;
        res_ord_nxt    = '0;
        res_idx_nxt    = '0;
        hsel           = fk;
        if (op_r == OP_ALLOC) begin
          if (zero_r) begin
            res_status_nxt = RS_ZERO_SIZE;
            state_nxt      = S_FIN;
          end else if (big_r) begin
            res_status_nxt = RS_TOO_LARGE;
            state_nxt      = S_FIN;
          end else if (!found) begin
            res_status_nxt = RS_NO_FREE;
            state_nxt      = S_FIN;
          end else begin
            k_nxt     = fk;
            idx_nxt   = hd;
            state_nxt = S_A_SPLIT_CHECK;
          end
        end else begin
          if (oor_r) begin
            res_status_nxt = RS_OUT_OF_RANGE;
            state_nxt      = S_FIN;
          end else begin
            k_nxt     = '0;
            state_nxt = S_F_SCAN;
          end
        end
      end

      // Split the found block downward until the requested order is reached.
      S_A_SPLIT_CHECK: begin
        if (k_r > req_r) begin
          lop_nxt   = LOP_REMOVE;
          lk_nxt    = k_r;
          lidx_nxt  = idx_r;
          ret_nxt   = S_A_SPLIT_MARK;
          state_nxt = S_L_START;
        end else begin
          state_nxt = S_A_TAKE;
        end
      end

      S_A_SPLIT_MARK: begin
        tbl.st_we    = 1'b1;
        tbl.st_waddr = slot(k_r, idx_r);
        tbl.st_wdata = ST_SPLIT;
        tbl.ln_we    = 1'b1;
        tbl.ln_waddr = slot(k_r, idx_r);
        state_nxt    = S_A_CHILD0;
      end

      S_A_CHILD0: begin
        tbl.st_we    = 1'b1;
        tbl.st_waddr = slot(k_r - ORD_W'(1), idx_r << 1);
        tbl.st_wdata = ST_FREE;
        lop_nxt      = LOP_APPEND;
        lk_nxt       = k_r - ORD_W'(1);
        lidx_nxt     = idx_r << 1;
        ret_nxt      = S_A_CHILD1;
        state_nxt    = S_L_START;
      end

      S_A_CHILD1: begin
        tbl.st_we    = 1'b1;
        tbl.st_waddr = slot(k_r - ORD_W'(1), (idx_r << 1) | IDX_W'(1));
        tbl.st_wdata = ST_FREE;
        lop_nxt      = LOP_APPEND;
        lk_nxt       = k_r - ORD_W'(1);
        lidx_nxt     = (idx_r << 1) | IDX_W'(1);
        ret_nxt      = S_A_DESC;
        state_nxt    = S_L_START;
      end

      S_A_DESC: begin
        k_nxt     = k_r - ORD_W'(1);
        idx_nxt   = idx_r << 1;
        state_nxt = S_A_SPLIT_CHECK;
      end

      // Take the head of the requested order's list.
      S_A_TAKE: begin
        hsel         = req_r;
        idx_nxt      = hd;
        tbl.st_raddr = slot(req_r, hd);
        state_nxt    = S_A_TAKE_W;
      end

      S_A_TAKE_W: begin
        res_ord_nxt = req_r;
        res_idx_nxt = idx_r;
        if (st_rdata != ST_ALLOC) begin
          tbl.st_we    = 1'b1;
          tbl.st_waddr = slot(req_r, idx_r);
          tbl.st_wdata = ST_ALLOC;
          lop_nxt      = LOP_REMOVE;
          lk_nxt       = req_r;
          lidx_nxt     = idx_r;
          ret_nxt      = S_A_TAKE_L;
          state_nxt    = S_L_START;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_A_TAKE_L: begin
        tbl.ln_we    = 1'b1;
        tbl.ln_waddr = slot(req_r, idx_r);
        state_nxt    = S_FIN;
      end

      // Free: look for the allocated block covering the page, lowest order first.
      S_F_SCAN: begin
        tbl.st_raddr = slot(k_r, pidx);
        state_nxt    = S_F_SCAN_W;
      end

      S_F_SCAN_W: begin
        hsel = k_r;
        if (CNT_W'(pidx) < order_cnt(k_r) && st_rdata == ST_ALLOC) begin
          tbl.st_we          = 1'b1;
          tbl.st_waddr       = slot(k_r, pidx);
          tbl.st_wdata       = ST_FREE;
          tbl.ln_we          = 1'b1;
          tbl.ln_waddr       = slot(k_r, pidx);
          tbl.ln_wdata.valid = hv_r[k_r];
          tbl.ln_wdata.idx   = hv_r[k_r] ? hd : '0;
          hv_nxt[k_r]        = 1'b1;
          head_nxt[k_r]      = pidx;
          idx_nxt            = pidx;
          res_ord_nxt        = k_r;
          res_idx_nxt        = pidx;
          state_nxt          = S_F_BUD;
        end else if (k_r == TOP_ORDER) begin
          res_status_nxt = RS_NOT_ALLOC;
          state_nxt      = S_FIN;
        end else begin
          k_nxt     = k_r + ORD_W'(1);
          state_nxt = S_F_SCAN;
        end
      end

      // Merge with the buddy while it is free.
      S_F_BUD: begin
        if (k_r == TOP_ORDER || CNT_W'(bud) >= order_cnt(k_r)) begin
          state_nxt = S_FIN;
        end else begin
          tbl.st_raddr = slot(k_r, bud);
          state_nxt    = S_F_BUD_W;
        end
      end

      S_F_BUD_W: begin
        if (st_rdata != ST_FREE) begin
          state_nxt = S_FIN;
        end else begin
          lop_nxt   = LOP_REMOVE;
          lk_nxt    = k_r;
          lidx_nxt  = idx_r;
          ret_nxt   = S_F_RM_BUD;
          state_nxt = S_L_START;
        end
      end

      S_F_RM_BUD: begin
        lop_nxt   = LOP_REMOVE;
        lk_nxt    = k_r;
        lidx_nxt  = bud;
        ret_nxt   = S_F_MERGE;
        state_nxt = S_L_START;
      end

      S_F_MERGE: begin
        tbl.st_we    = 1'b1;
        tbl.st_waddr = slot(k_r, idx_r);
        tbl.st_wdata = ST_BELONGS;
        tbl.ln_we    = 1'b1;
        tbl.ln_waddr = slot(k_r, idx_r);
        state_nxt    = S_F_MERGE2;
      end

      S_F_MERGE2: begin
        tbl.st_we    = 1'b1;
        tbl.st_waddr = slot(k_r, bud);
        tbl.st_wdata = ST_BELONGS;
        tbl.ln_we    = 1'b1;
        tbl.ln_waddr = slot(k_r, bud);
        k_nxt        = k_r + ORD_W'(1);
        idx_nxt      = idx_r >> 1;
        state_nxt    = S_F_UP;
      end

      S_F_UP: begin
        hsel               = k_r;
        tbl.st_we          = 1'b1;
        tbl.st_waddr       = slot(k_r, idx_r);
        tbl.st_wdata       = ST_FREE;
        tbl.ln_we          = 1'b1;
        tbl.ln_waddr       = slot(k_r, idx_r);
        tbl.ln_wdata.valid = hv_r[k_r];
        tbl.ln_wdata.idx   = hv_r[k_r] ? hd : '0;
        hv_nxt[k_r]        = 1'b1;
        head_nxt[k_r]      = idx_r;
        state_nxt          = S_F_BUD;
      end

      // Shared list routine: remove or append block lidx_r on list lk_r.
      S_L_START: begin
        if (lop_r == LOP_APPEND) begin
          tbl.ln_we    = 1'b1;
          tbl.ln_waddr = ls;
          if (!hv_r[lk_r]) begin
            hv_nxt[lk_r]   = 1'b1;
            head_nxt[lk_r] = lidx_r;
            state_nxt      = ret_r;
          end else begin
            cur_nxt   = hd;
            n_nxt     = '0;
            state_nxt = S_L_READ;
          end
        end else begin
          if (!hv_r[lk_r]) begin
            state_nxt = ret_r;
          end else if (hd == lidx_r) begin
            tbl.ln_raddr = ls;
            state_nxt    = S_L_RHEAD;
          end else begin
            cur_nxt   = hd;
            n_nxt     = '0;
            state_nxt = S_L_READ;
          end
        end
      end

      S_L_RHEAD: begin
        hv_nxt[lk_r]   = ln_rdata.valid;
        head_nxt[lk_r] = ln_rdata.idx;
        state_nxt      = ret_r;
      end

      S_L_READ: begin
        // The walk is bounded by the number of blocks of the order plus one.
        if (n_r > order_cnt(lk_r)) begin
          state_nxt = ret_r;
        end else begin
          tbl.ln_raddr = slot(lk_r, cur_r);
          state_nxt    = S_L_EVAL;
        end
      end

      S_L_EVAL: begin
        if (!ln_rdata.valid) begin
          if (lop_r == LOP_APPEND) begin
            tbl.ln_we          = 1'b1;
            tbl.ln_waddr       = slot(lk_r, cur_r);
            tbl.ln_wdata.valid = 1'b1;
            tbl.ln_wdata.idx   = lidx_r;
          end
          state_nxt = ret_r;
        end else if (lop_r == LOP_REMOVE && ln_rdata.idx == lidx_r) begin
          tbl.ln_raddr = ls;
          state_nxt    = S_L_RFIX;
        end else begin
          cur_nxt   = ln_rdata.idx;
          n_nxt     = n_r + CNT_W'(1);
          state_nxt = S_L_READ;
        end
      end

      S_L_RFIX: begin
        tbl.ln_we    = 1'b1;
        tbl.ln_waddr = slot(lk_r, cur_r);
        tbl.ln_wdata = ln_rdata;
        state_nxt    = ret_r;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ord_nxt    = res_ord_r;
          out_idx_nxt    = res_idx_r;
          out_addr_nxt   = 32'd0;
          if (res_status_r == RS_OK && op_r == OP_ALLOC) begin
            out_addr_nxt = base_r + (32'(res_idx_r) << (32'(res_ord_r) + PAGE_SHIFT));
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      hv_r        <= {(order_cnt(TOP_ORDER) != '0), {(ORDER_COUNT-1){1'b0}}};
      for (int j = 0; j < ORDER_COUNT; j++) head_r[j] <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      hv_r        <= hv_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    lop_r        <= lop_nxt;
    lk_r         <= lk_nxt;
    lidx_r       <= lidx_nxt;
    cur_r        <= cur_nxt;
    n_r          <= n_nxt;
    op_r         <= op_nxt;
    zero_r       <= zero_nxt;
    big_r        <= big_nxt;
    oor_r        <= oor_nxt;
    req_r        <= req_nxt;
    page_r       <= page_nxt;
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_ord_r    <= res_ord_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ord_r    <= out_ord_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_block_order    = out_ord_r;
  assign out_block_index    = out_idx_r;

endmodule

[verif/buddy_page_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the buddy page allocator: directed and random beats.
// Depends on bpa_pkg and the buddy_page_allocator RTL; everything else is built in.
module buddy_page_allocator_tb
  import bpa_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 64_000_000;
  localparam int unsigned NSLOTS = 2 * NUM_PAGES;

  // One expected result beat.
  typedef struct {
    rstat_t      status;
    logic [31:0] addr;
    logic [2:0]  order;
    logic [9:0]  index;
  } alloc_result_t;

  // A block handed out by the allocator, kept relative to base_address so that
  // it can still be released after the base moves.
  typedef struct {
    logic [31:0] offset;
    int unsigned order;
  } live_block_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [31:0] in_alloc_size;
  logic [31:0] in_free_address;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_result_address;
  logic [2:0]  out_block_order;
  logic [9:0]  out_block_index;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  buddy_page_allocator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_alloc_size      (in_alloc_size),
    .in_free_address    (in_free_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_block_order    (out_block_order),
    .out_block_index    (out_block_index),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Predictor state: a private copy of the allocator tables.
  bstat_t      blk_state [NSLOTS];
  int unsigned blk_next  [NSLOTS];
  bit          blk_linked[NSLOTS];
  int unsigned list_head [ORDER_COUNT];
  bit          list_used [ORDER_COUNT];
  int unsigned tier_first[ORDER_COUNT];
  int unsigned tier_len  [ORDER_COUNT];
  logic [31:0] page_base;

  alloc_result_t pending_results[$];
  live_block_t   live_blocks[$];

  int unsigned cycles = 0;
  int unsigned failures;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned alloc_ok;
  int unsigned free_ok;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Clock and cycle watchdog. The watchdog gives up on a hung or slow design.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_page_allocator: mismatch");
      $finish;
    end
  end

  function automatic int unsigned tbl(int unsigned k, int unsigned i);
    return (tier_first[k] + i) % NSLOTS;
  endfunction

  // Free-list helpers. Lists are singly linked through blk_next.
  function automatic void unlink_block(int unsigned k, int unsigned i);
    int unsigned cur;
    int unsigned s;
    if (!list_used[k]) return;
    if (list_head[k] == i) begin
      s = tbl(k, i);
      list_used[k] = blk_linked[s];
      list_head[k] = blk_next[s];
      return;
    end
    cur = list_head[k];
    for (int unsigned n = 0; n <= tier_len[k]; n++) begin
      s = tbl(k, cur);
      if (!blk_linked[s]) return;
      if (blk_next[s] == i) begin
        blk_next[s]   = blk_next[tbl(k, i)];
        blk_linked[s] = blk_linked[tbl(k, i)];
        return;
      end
      cur = blk_next[s];
    end
  endfunction

  function automatic void add_tail(int unsigned k, int unsigned i);
    int unsigned cur;
    int unsigned s;
    blk_linked[tbl(k, i)] = 1'b0;
    blk_next[tbl(k, i)]   = 0;
    if (!list_used[k]) begin
      list_used[k] = 1'b1;
      list_head[k] = i;
      return;
    end
    cur = list_head[k];
    for (int unsigned n = 0; n <= tier_len[k]; n++) begin
      s = tbl(k, cur);
      if (!blk_linked[s]) begin
        blk_linked[s] = 1'b1;
        blk_next[s]   = i;
        return;
      end
      cur = blk_next[s];
    end
  endfunction

  function automatic void add_head(int unsigned k, int unsigned i);
    int unsigned s;
    s = tbl(k, i);
    blk_linked[s] = list_used[k];
    blk_next[s]   = list_used[k] ? list_head[k] : 0;
    list_used[k]  = 1'b1;
    list_head[k]  = i;
  endfunction

  // Splitting a block frees both halves one order down, left half first.
  function automatic void halve_block(int unsigned k, int unsigned i);
    unlink_block(k, i);
    blk_state[tbl(k, i)]  = ST_SPLIT;
    blk_linked[tbl(k, i)] = 1'b0;
    blk_state[tbl(k - 1, 2 * i)] = ST_FREE;
    add_tail(k - 1, 2 * i);
    blk_state[tbl(k - 1, 2 * i + 1)] = ST_FREE;
    add_tail(k - 1, 2 * i + 1);
  endfunction

  // Power-on contents: only the top order is populated, all of it on one list.
  function automatic void reset_tables();
    int unsigned acc;
    int unsigned top;
    acc = 0;
    page_base = '0;
    for (int unsigned s = 0; s < NSLOTS; s++) begin
      blk_state[s]  = ST_BELONGS;
      blk_next[s]   = 0;
      blk_linked[s] = 1'b0;
    end
    for (int unsigned k = 0; k < ORDER_COUNT; k++) begin
      tier_first[k] = acc;
      tier_len[k]   = NUM_PAGES >> k;
      acc += tier_len[k];
      list_used[k] = 1'b0;
      list_head[k] = 0;
    end
    top = ORDER_COUNT - 1;
    for (int unsigned i = 0; i < tier_len[top]; i++) begin
      blk_state[tbl(top, i)]  = ST_FREE;
      blk_linked[tbl(top, i)] = (i + 1 < tier_len[top]);
      blk_next[tbl(top, i)]   = (i + 1 < tier_len[top]) ? i + 1 : 0;
    end
    list_used[top] = tier_len[top] > 0;
  endfunction

  // Works out the result of one accepted beat and updates the tables.
  function automatic alloc_result_t predict_request(op_t op, logic [31:0] size,
                                                    logic [31:0] faddr);
    alloc_result_t r;
    longint unsigned pages;
    longint unsigned a;
    int unsigned req;
    int unsigned k;
    int unsigned i;
    int unsigned page;
    int unsigned bud;
    r.status = RS_OK;
    r.addr   = '0;
    r.order  = '0;
    r.index  = '0;
    if (op == OP_ALLOC) begin
      pages = (longint'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
      req = 0;
      while (req < ORDER_COUNT && (longint'(1) << req) < pages) req++;
      if (size == 0) r.status = RS_ZERO_SIZE;
      else if (req >= ORDER_COUNT) r.status = RS_TOO_LARGE;
      else begin
        k = req;
        while (k < ORDER_COUNT && !list_used[k]) k++;
        if (k >= ORDER_COUNT) r.status = RS_NO_FREE;
        else begin
          i = list_head[k];
          for (int unsigned j = k; j > req; j--) begin
            halve_block(j, i);
            i = i * 2;
          end
          // The taken block is the head of the list, which need not be the
          // left child just made since children go to the tail.
          i = list_head[req];
          if (blk_state[tbl(req, i)] != ST_ALLOC) begin
            blk_state[tbl(req, i)] = ST_ALLOC;
            unlink_block(req, i);
            blk_linked[tbl(req, i)] = 1'b0;
            blk_next[tbl(req, i)]   = 0;
          end
          r.addr  = 32'(longint'(page_base) + ((longint'(i) << req) * PAGE_BYTES));
          r.order = 3'(req);
          r.index = 10'(i);
        end
      end
    end else begin
      a = faddr;
      if (a < page_base || a - page_base >= longint'(NUM_PAGES) * PAGE_BYTES)
        r.status = RS_OUT_OF_RANGE;
      else begin
        page = (a - page_base) / PAGE_BYTES;
        for (k = 0; k < ORDER_COUNT; k++) begin
          i = page >> k;
          if (i < tier_len[k] && blk_state[tbl(k, i)] == ST_ALLOC) break;
        end
        if (k >= ORDER_COUNT) r.status = RS_NOT_ALLOC;
        else begin
          r.order = 3'(k);
          r.index = 10'(i);
          blk_state[tbl(k, i)] = ST_FREE;
          add_head(k, i);
          // Merge upward while the buddy exists and is free.
          while (k < ORDER_COUNT - 1) begin
            bud = i ^ 1;
            if (bud >= tier_len[k] || blk_state[tbl(k, bud)] != ST_FREE) break;
            unlink_block(k, i);
            unlink_block(k, bud);
            blk_state[tbl(k, i)]    = ST_BELONGS;
            blk_linked[tbl(k, i)]   = 1'b0;
            blk_state[tbl(k, bud)]  = ST_BELONGS;
            blk_linked[tbl(k, bud)] = 1'b0;
            k++;
            i = i >> 1;
            blk_state[tbl(k, i)] = ST_FREE;
            add_head(k, i);
          end
        end
      end
    end
    return r;
  endfunction

  // Result receiver: random back-pressure set at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: every accepted result beat is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_status);
        failures++;
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          failures++;
        end
        if (out_result_address !== e.addr) begin
          $error("result_address: expected %h, got %h", e.addr, out_result_address);
          failures++;
        end
        if (out_block_order !== e.order) begin
          $error("block_order: expected %0d, got %0d", e.order, out_block_order);
          failures++;
        end
        if (out_block_index !== e.index) begin
          $error("block_index: expected %0d, got %0d", e.index, out_block_index);
          failures++;
        end
      end
    end
  end

  // Sends one request beat. Valid stays high from one beat to the next unless
  // the sender decides to idle, so back-to-back beats see no bubble.
  task automatic send_request(op_t op, logic [31:0] size, logic [31:0] faddr);
    alloc_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_alloc_size   <= size;
    in_free_address <= faddr;
    do @(posedge clk); while (!in_ready);
    r = predict_request(op, size, faddr);
    pending_results.push_back(r);
    beats_sent++;
    if (r.status == RS_OK) begin
      if (op == OP_ALLOC) begin
        live_blocks.push_back('{r.addr - page_base, r.order});
        alloc_ok++;
      end else begin
        free_ok++;
      end
    end
  endtask

  // Lets every outstanding beat come back, then moves the base address.
  task automatic set_base(logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    page_base = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Releases a random live block through an address anywhere inside it.
  task automatic free_live_block(bit inner);
    int unsigned n;
    live_block_t b;
    logic [31:0] span;
    n = $urandom_range(live_blocks.size() - 1);
    b = live_blocks[n];
    live_blocks.delete(n);
    span = (PAGE_BYTES << b.order) - 1;
    send_request(OP_FREE, '0, page_base + b.offset + (inner ? $urandom_range(span) : 0));
  endtask

  // Directed cases: size edges, every status code, exhaustion of the whole
  // space, range edges of a free and a free that merges back to the top.
  task automatic test_directed();
    logic [31:0] span;
    span = NUM_PAGES * PAGE_BYTES;
    set_base(32'h1000_0000);
    send_request(OP_ALLOC, 32'd0, '0);                    // zero size
    send_request(OP_ALLOC, 32'd1, '0);                    // one byte, order 0
    send_request(OP_ALLOC, PAGE_BYTES + 1, '0);           // just over a page
    send_request(OP_ALLOC, PAGE_BYTES << (ORDER_COUNT - 1), '0);     // largest order
    send_request(OP_ALLOC, (PAGE_BYTES << (ORDER_COUNT - 1)) + 1, '0); // oversize
    send_request(OP_ALLOC, 32'hFFFF_FFFF, '0);            // size at the maximum
    send_request(OP_FREE, '0, 32'h0FFF_FFFF);             // just below the base
    send_request(OP_FREE, '0, 32'h1000_0000 + span);      // just past the end
    send_request(OP_FREE, '0, 32'h0000_0000);             // address zero, outside
    send_request(OP_FREE, '0, 32'hFFFF_FFFF);
    send_request(OP_FREE, '0, 32'h1000_0000 + span - 1);  // never allocated
    // Release everything taken so far, each one by a random address inside the block.
    while (live_blocks.size() > 0) free_live_block(1'b1);
    // Drain the space with top-order blocks until the allocator runs dry.
    for (int n = 0; n <= (NUM_PAGES >> (ORDER_COUNT - 1)); n++)
      send_request(OP_ALLOC, PAGE_BYTES << (ORDER_COUNT - 1), '0);
    send_request(OP_ALLOC, 32'd1, '0);                    // still exhausted
    while (live_blocks.size() > 0) free_live_block(1'b0);
    send_request(OP_FREE, '0, 32'h1000_0000);             // double free
  endtask

  // Random traffic: mostly well-formed allocate and free of live blocks with
  // random sizes, plus noise beats with arbitrary sizes and addresses.
  task automatic test_random(int unsigned count, logic [31:0] base_value);
    int unsigned pick;
    logic [31:0] size;
    set_base(base_value);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50 || (pick < 85 && live_blocks.size() == 0)) begin
        case ($urandom_range(9))
          0:       size = $urandom();
          1:       size = 0;
          2, 3:    size = $urandom_range(PAGE_BYTES << (ORDER_COUNT - 1), 1);
          default: size = $urandom_range(4 * PAGE_BYTES, 1);
        endcase
        send_request(OP_ALLOC, size, '0);
      end else if (pick < 85) begin
        free_live_block($urandom_range(1));
      end else if (pick < 93) begin
        send_request(OP_FREE, '0, page_base + $urandom_range(NUM_PAGES * PAGE_BYTES - 1));
      end else begin
        send_request(OP_FREE, '0, $urandom());
      end
    end
  endtask

  initial begin
    failures = 0;
    beats_sent = 0;
    beats_checked = 0;
    alloc_ok = 0;
    free_ok = 0;
    send_idle_pct = 20;
    recv_idle_pct = 59;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_alloc_size = '0;
    in_free_address = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    reset_tables();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(460, 32'h0000_0000);
    send_idle_pct = 59;
    recv_idle_pct = 20;
    test_random(460, 32'hFFFF_F000);   // results wrap past the top of memory
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(230, 32'hFFFF_FFFF);
    test_random(230, $urandom());

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (64) @(posedge clk);
    $display("Covered %0d request beats (%0d allocations and %0d frees succeeded),",
             beats_sent, alloc_ok, free_ok);
    $display("%0d results checked over five base addresses in %0d cycles.",
             beats_checked, cycles);
    if (failures == 0) begin
      $display("buddy_page_allocator: match");
    end else begin
      $display("buddy_page_allocator: mismatch");
    end
    $finish;
  end

endmodule
